### rtl/sha512_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared types, constants and round functions for the SHA-512 stream hasher.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int BLOCK_BYTES_DEF = 128;
    localparam int PAD_LIMIT       = 112;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // Control from sequencer to the round unit.
    typedef struct packed {
        logic       load;    // copy hash words into working vars
        logic       step;    // run one round
        logic       fold;    // add working vars into hash words
        logic       init;    // restore initial hash
        logic [6:0] rnd;     // round number 0..79
    } rnd_ctl_t;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        ror64 = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] r;
        unique case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

### rtl/sha512_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 message schedule
// 16-word shift window; bytes pack in big-endian, rounds shift out W[t].
// ----------------------------------------------------------------------------
module sha512_sched (
    input  logic        clk,
    input  logic        byte_we,
    input  logic [6:0]  byte_pos,
    input  logic [7:0]  byte_val,
    input  logic        len_we,
    input  logic [63:0] len_hi,
    input  logic [63:0] len_lo,
    input  logic        shift,
    output logic [63:0] w_cur
);

    logic [63:0] win_reg [16];
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] w_new;

    assign w_cur = win_reg[0];
    assign s0 = sha512_pkg::ror64(win_reg[1], 1) ^ sha512_pkg::ror64(win_reg[1], 8)
              ^ (win_reg[1] >> 7);
    assign s1 = sha512_pkg::ror64(win_reg[14], 19) ^ sha512_pkg::ror64(win_reg[14], 61)
              ^ (win_reg[14] >> 6);
    assign w_new = s1 + win_reg[9] + s0 + win_reg[0];

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
        else if (len_we)
        begin
            win_reg[14] <= len_hi;
            win_reg[15] <= len_lo;
        end
        else if (byte_we)
        begin
            win_reg[byte_pos[6:3]][(7 - byte_pos[2:0]) * 8 +: 8] <= byte_val;
        end
    end

endmodule

### rtl/sha512_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 round unit
// Eight working variables, one round per cycle while step is set, fold into hash words.
// ----------------------------------------------------------------------------
module sha512_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha512_pkg::rnd_ctl_t ctl,
    input  logic [63:0]          w_cur,
    input  logic [2:0]           rd_idx,
    output logic [63:0]          hash_out
);

    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] big0;
    logic [63:0] big1;
    logic [63:0] chs;
    logic [63:0] mj;

    assign hash_out = h_reg[rd_idx];
    assign big1 = sha512_pkg::ror64(v_reg[4], 14) ^ sha512_pkg::ror64(v_reg[4], 18)
                ^ sha512_pkg::ror64(v_reg[4], 41);
    assign chs  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign big0 = sha512_pkg::ror64(v_reg[0], 28) ^ sha512_pkg::ror64(v_reg[0], 34)
                ^ sha512_pkg::ror64(v_reg[0], 39);
    assign mj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1   = v_reg[7] + big1 + chs + sha512_pkg::ROUND_K[ctl.rnd] + w_cur;
    assign t2   = big0 + mj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha512_pkg::init_hash(3'(i));
            end
        end
        else if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha512_pkg::init_hash(3'(i));
            end
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (ctl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

### rtl/sha512_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 stream hasher
// Byte-serial SHA-512 with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): one word per byte; has_byte marks
//   a real byte, end_of_message closes the message (after this word's byte).
//   out channel (out_valid/out_ready/out_data): eight digest words, index
//   0..7, last_word on index 7.
// Timing:
//   A byte that does not fill a block leaves the hasher idle. A full block runs
//   load, 80 rounds on the shared round unit, and fold. End of message
//   writes the pad bytes one per cycle, then runs one or two
//   compressions, then 8 output words, one per cycle the receiver takes.
//   in_ready is low during all of this.
// Reset: hash words go to the initial value, counters clear; the block
//   buffer is not cleared, padding writes every byte it reads.
// Stall: a held digest word stays on out_data (read from the hash words) until taken.
// ----------------------------------------------------------------------------
module sha512_stream_hasher #(
    parameter int BLOCK_BYTES = sha512_pkg::BLOCK_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha512_pkg::in_word_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha512_pkg::out_word_t out_data
);

    localparam int FW = $clog2(BLOCK_BYTES);

    sha512_pkg::state_t   state_reg, state_next;
    sha512_pkg::rnd_ctl_t ctl;

    logic [FW-1:0]  fill_reg, fill_next;
    logic [127:0]   len_reg, len_next;
    logic [6:0]     rnd_reg, rnd_next;
    logic [2:0]     idx_reg, idx_next;
    logic           fin_reg, fin_next;   // set when the length is written, before its block is compressed
    logic           eom_reg, eom_next;   // end pending after current compression
    logic           load_reg, load_next; // first round cycle loads work vars

    logic           byte_we;
    logic [7:0]     byte_val;
    logic           len_we;
    logic           shift;
    logic [63:0]    w_cur;
    logic [63:0]    hash_out;
    logic           acc;

    assign acc      = in_valid && in_ready;
    assign in_ready = (state_reg == sha512_pkg::ST_IDLE);

    sha512_sched u_sched (
        .clk      (clk),
        .byte_we  (byte_we),
        .byte_pos (fill_reg),
        .byte_val (byte_val),
        .len_we   (len_we),
        .len_hi   (len_reg[127:64]),
        .len_lo   (len_reg[63:0]),
        .shift    (shift),
        .w_cur    (w_cur)
    );

    sha512_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .w_cur    (w_cur),
        .rd_idx   (idx_reg),
        .hash_out (hash_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        eom_next   = eom_reg;
        load_next  = 1'b0;
        unique case (state_reg)
            sha512_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    if (in_data.has_byte)
                    begin
                        fill_next = fill_reg + 1'b1;
                        len_next  = len_reg + 128'd8;
                        if (fill_reg == FW'(BLOCK_BYTES - 1))
                        begin
                            eom_next   = in_data.end_of_message;
                            load_next  = 1'b1;
                            rnd_next   = '0;
                            state_next = sha512_pkg::ST_ROUND;
                        end
                        else if (in_data.end_of_message)
                        begin
                            state_next = sha512_pkg::ST_PAD;
                        end
                    end
                    else if (in_data.end_of_message)
                    begin
                        state_next = sha512_pkg::ST_PAD;
                    end
                end
            end
            sha512_pkg::ST_PAD:
            begin
                // first PAD cycle writes the mark, following ones zeros
                fill_next = fill_reg + 1'b1;
                eom_next  = 1'b1;
                if (fill_reg == FW'(BLOCK_BYTES - 1))
                begin
                    load_next  = 1'b1;
                    rnd_next   = '0;
                    state_next = sha512_pkg::ST_ROUND;
                end
                else if (fill_reg == FW'(sha512_pkg::PAD_LIMIT - 1))
                begin
                    state_next = sha512_pkg::ST_LEN;
                end
            end
            sha512_pkg::ST_LEN:
            begin
                fill_next  = '0;
                fin_next   = 1'b1;
                load_next  = 1'b1;
                rnd_next   = '0;
                state_next = sha512_pkg::ST_ROUND;
            end
            sha512_pkg::ST_ROUND:
            begin
                if (!load_reg)
                begin
                    rnd_next = rnd_reg + 1'b1;
                    if (rnd_reg == 7'd79)
                    begin
                        state_next = sha512_pkg::ST_FOLD;
                    end
                end
            end
            sha512_pkg::ST_FOLD:
            begin
                if (fin_reg)
                begin
                    idx_next   = '0;
                    state_next = sha512_pkg::ST_EMIT;
                end
                else if (eom_reg)
                begin
                    state_next = sha512_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha512_pkg::ST_IDLE;
                end
            end
            sha512_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        fin_next   = 1'b0;
                        eom_next   = 1'b0;
                        len_next   = '0;
                        fill_next  = '0;
                        state_next = sha512_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = sha512_pkg::ST_IDLE;
        endcase
    end

    // outputs
    // The pad mark goes in on the first PAD cycle of a message, tracked by
    // whether the mark has been placed already (mark_reg).
    logic mark_reg, mark_next;

    always_comb
    begin
        byte_we  = 1'b0;
        byte_val = in_data.data_byte;
        len_we   = 1'b0;
        shift    = 1'b0;
        ctl      = '0;
        ctl.rnd  = rnd_reg;
        mark_next = mark_reg;
        unique case (state_reg)
            sha512_pkg::ST_IDLE:
            begin
                byte_we = acc && in_data.has_byte;
            end
            sha512_pkg::ST_PAD:
            begin
                byte_we   = 1'b1;
                byte_val  = mark_reg ? 8'h00 : sha512_pkg::PAD_MARK;
                mark_next = 1'b1;
            end
            sha512_pkg::ST_LEN:
            begin
                len_we = 1'b1;
            end
            sha512_pkg::ST_ROUND:
            begin
                ctl.load = load_reg;
                ctl.step = !load_reg;
                shift    = !load_reg;
            end
            sha512_pkg::ST_FOLD:
            begin
                ctl.fold = 1'b1;
            end
            sha512_pkg::ST_EMIT:
            begin
                if (out_ready && idx_reg == 3'd7)
                begin
                    ctl.init  = 1'b1;
                    mark_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // PAD after an end-triggered full block must not jump to LEN early:
    // fill wraps to 0 with the block's last byte, so the LEN test at 111 holds.
    // A second pad block begins with zeros since mark_reg is already set.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha512_pkg::ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            eom_reg   <= 1'b0;
            load_reg  <= 1'b0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            eom_reg   <= eom_next;
            load_reg  <= load_next;
            mark_reg  <= mark_next;
        end
    end

    assign out_valid            = (state_reg == sha512_pkg::ST_EMIT);
    assign out_data.digest_word = hash_out;
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == 3'd7);

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha512_pkg::ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");

    a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha512_pkg::ST_ROUND && !load_reg && rnd_reg == 7'd79)
        |=> (state_reg == sha512_pkg::ST_FOLD))
        else $error("round count did not end in fold");

    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && idx_reg != 3'd7) |=> (out_valid && idx_reg != 3'd0))
        else $error("digest words out of order");

endmodule
